FILE: design/hsv_color_segmenter_top_assert.svh
// Assertion macros shared by the segmenter modules.
`ifndef HSV_COLOR_SEGMENTER_TOP_ASSERT_SVH
`define HSV_COLOR_SEGMENTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HSVSEG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSVSEG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hsvseg_pkg.sv
package hsvseg_pkg;

  localparam int NUM_CLS = 4;

  typedef logic [1:0] cls_t;
  typedef logic [NUM_CLS-1:0] flags_t;

  localparam cls_t CLS_RED    = 2'd0;
  localparam cls_t CLS_YELLOW = 2'd1;
  localparam cls_t CLS_GREEN  = 2'd2;
  localparam cls_t CLS_BLUE   = 2'd3;

  localparam logic CMD_TALLY = 1'b0;
  localparam logic CMD_MASK  = 1'b1;

  localparam logic [7:0] MASK_HIT  = 8'd0;
  localparam logic [7:0] MASK_MISS = 8'd255;

  typedef struct packed {
    logic   upd;
    logic   clear;
    flags_t flags;
  } tally_req_t;

endpackage

FILE: design/hsvseg_classify.sv
module hsvseg_classify (
  input  logic [7:0]        blue,
  input  logic [7:0]        green,
  input  logic [7:0]        red,
  output hsvseg_pkg::flags_t flags
);
  import hsvseg_pkg::*;

  localparam int W = 20;

  logic [7:0]   mx;
  logic [7:0]   mn;
  logic [W-1:0] d;
  logic [W-1:0] m;
  logic [W-1:0] hn;
  logic         hit_red;
  logic         hit_yel;
  logic         hit_grn;
  logic         hit_blu;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    d = W'(mx - mn);
    m = W'(mx);
  end

  always_comb begin
    if (red == mx) begin
      if (green >= blue) begin
        hn = W'(60) * W'(green - blue);
      end else begin
        hn = W'(360) * d - W'(60) * W'(blue - green);
      end
    end else if (green == mx) begin
      hn = W'(120) * d + W'(60) * W'(blue) - W'(60) * W'(red);
    end else begin
      hn = W'(240) * d + W'(60) * W'(red) - W'(60) * W'(green);
    end
  end

  always_comb begin
    hit_red = ((hn > W'(356) * d) || (W'(10) * hn < W'(84) * d)) &&
              (W'(100) * d > W'(63) * m) && (W'(100) * d < W'(88) * m) &&
              (W'(100) * m > W'(38 * 255));
    hit_yel = (hn > W'(52) * d) && (hn < W'(58) * d) &&
              (W'(100) * d > W'(65) * m) && (W'(100) * d < W'(80) * m) &&
              (W'(100) * m > W'(50 * 255));
    hit_grn = (hn > W'(75) * d) && (hn < W'(88) * d) &&
              (W'(100) * d > W'(45) * m) && (W'(100) * d < W'(80) * m) &&
              (W'(100) * m > W'(57 * 255));
    hit_blu = (hn > W'(213) * d) && (hn < W'(223) * d) &&
              (W'(100) * d > W'(40) * m) && (d < W'(6) * m) &&
              (W'(100) * m < W'(52 * 255)) && (W'(100) * m > W'(40 * 255));
    flags = '0;
    if (d != '0) begin
      flags[CLS_RED]    = hit_red;
      flags[CLS_YELLOW] = hit_yel;
      flags[CLS_GREEN]  = hit_grn;
      flags[CLS_BLUE]   = hit_blu;
    end
  end

endmodule

FILE: design/hsvseg_tally.sv
`include "hsv_color_segmenter_top_assert.svh"

module hsvseg_tally #(
  parameter int COUNT_BITS = 21
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  hsvseg_pkg::tally_req_t req,
  output hsvseg_pkg::cls_t       dominant
);
  import hsvseg_pkg::*;

  logic [COUNT_BITS-1:0] cnt_r   [NUM_CLS];
  logic [COUNT_BITS-1:0] cnt_nxt [NUM_CLS];
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS-1:0] best_val;

  always_comb begin
    for (int k = 0; k < NUM_CLS; k++) begin
      base = req.clear ? '0 : cnt_r[k];
      if (req.upd) begin
        cnt_nxt[k] = (req.flags[k] && !(&base)) ? base + 1'b1 : base;
      end else begin
        cnt_nxt[k] = cnt_r[k];
      end
    end
  end

  // Pick the largest count; earlier classes win ties.
  always_comb begin
    dominant = CLS_RED;
    best_val = cnt_nxt[CLS_RED];
    if (cnt_nxt[CLS_YELLOW] > best_val) begin
      dominant = CLS_YELLOW;
      best_val = cnt_nxt[CLS_YELLOW];
    end
    if (cnt_nxt[CLS_GREEN] > best_val) begin
      dominant = CLS_GREEN;
      best_val = cnt_nxt[CLS_GREEN];
    end
    if (cnt_nxt[CLS_BLUE] > best_val) begin
      dominant = CLS_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CLS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (adv) begin
      for (int k = 0; k < NUM_CLS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  `HSVSEG_ASSERT_NXT(a_clear_bound, adv && req.upd && req.clear,
    (cnt_r[0] <= 1) && (cnt_r[1] <= 1) && (cnt_r[2] <= 1) && (cnt_r[3] <= 1),
    "count above one after frame clear")
  `HSVSEG_ASSERT_NXT(a_mask_keeps, adv && !req.upd,
    $stable(cnt_r[0]) && $stable(cnt_r[1]) && $stable(cnt_r[2]) && $stable(cnt_r[3]),
    "mask pixel changed counts")
  `HSVSEG_ASSERT_NXT(a_monotone, adv && req.upd && !req.clear,
    (cnt_r[0] >= $past(cnt_r[0])) && (cnt_r[1] >= $past(cnt_r[1])) &&
    (cnt_r[2] >= $past(cnt_r[2])) && (cnt_r[3] >= $past(cnt_r[3])),
    "count decreased without clear")

endmodule

FILE: design/hsv_color_segmenter_top.sv
// Request path: input register, one classify and count update, then result register.
// Throughput: one pixel per cycle unless out_tready stalls the output.
// Output register lets the input register fill while a result waits for out_tready.
// Reset (rst_n low, synchronous): pipeline empties and all class counts clear to zero.
`include "hsv_color_segmenter_top_assert.svh"

module hsv_color_segmenter_top #(
  parameter int COUNT_BITS = 21
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue[7:0], green[15:8], red[23:16]
  input  logic [1:0]  in_tuser,   // cmd[0], first_of_frame[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // mask_value[7:0], hit_flags[11:8], dominant[13:12]
);
  import hsvseg_pkg::*;

  logic       in_valid_r;
  logic       cmd_r;
  logic       first_r;
  logic [7:0] blue_r;
  logic [7:0] green_r;
  logic [7:0] red_r;
  logic       out_valid_r;
  logic [7:0] mask_r;
  flags_t     flags_r;
  cls_t       dom_r;

  logic       adv;
  flags_t     flags;
  cls_t       dominant;
  tally_req_t req;
  logic [7:0] mask_nxt;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || !out_valid_r || out_tready;

  hsvseg_classify u_classify (
    .blue  (blue_r),
    .green (green_r),
    .red   (red_r),
    .flags (flags)
  );

  assign req.upd   = (cmd_r == CMD_TALLY);
  assign req.clear = first_r;
  assign req.flags = flags;

  hsvseg_tally #(
    .COUNT_BITS (COUNT_BITS)
  ) u_tally (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .req      (req),
    .dominant (dominant)
  );

  assign mask_nxt = (cmd_r == CMD_MASK && flags[dominant]) ? MASK_HIT : MASK_MISS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser[0];
      first_r <= in_tuser[1];
      blue_r  <= in_tdata[7:0];
      green_r <= in_tdata[15:8];
      red_r   <= in_tdata[23:16];
    end
    if (adv) begin
      mask_r  <= mask_nxt;
      flags_r <= flags;
      dom_r   <= dominant;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, dom_r, flags_r, mask_r};

  `HSVSEG_ASSERT_IMP(a_hit_dominant, out_valid_r && (mask_r == MASK_HIT),
    flags_r[dom_r], "mask hit without dominant class flag")
  `HSVSEG_ASSERT_IMP(a_mask_code, out_valid_r,
    (mask_r == MASK_HIT) || (mask_r == MASK_MISS), "mask value out of code set")
  `HSVSEG_ASSERT_NXT(a_stage_hold, in_valid_r && !adv,
    in_valid_r && $stable(red_r) && $stable(cmd_r), "input stage lost a pending request")

endmodule
